FILE: rtl/core/polar_pad_plane_hit_locator_assert.svh
// ----------------------------------------------------------------------------
// polar pad plane hit locator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POLAR_PAD_PLANE_HIT_LOCATOR_ASSERT_SVH
`define POLAR_PAD_PLANE_HIT_LOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PPHL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pphl check failed");
`define PPHL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pphl check failed");
`else
`define PPHL_ASSERT_IMP(lbl, ante, cons)
`define PPHL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/pphl_pkg.sv
// ----------------------------------------------------------------------------
// pphl_pkg
// shared types and constants of the polar pad plane hit locator
// ----------------------------------------------------------------------------
package pphl_pkg;

  localparam int CORDIC_STEPS = 17;
  localparam int SQRT_BITS    = 15;
  localparam int LDIV_BITS    = 15;
  localparam int RDIV_BITS    = 22;

  localparam logic signed [49:0] SLOPE1  = 50'sd1779033704;
  localparam logic signed [49:0] SLOPE3  = 50'sd6074001000;
  localparam logic [30:0]        PI8_Q32 = 31'd1686629713;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

  localparam logic [16:0] STEP_ANGLE [CORDIC_STEPS] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024,
    17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2, 17'd1};

  localparam logic signed [19:0] SECTOR_CENTRE [8] = '{
    20'sd102944, 20'sd154416, 20'sd205887, -20'sd154416,
    -20'sd102944, -20'sd51472, 20'sd0, 20'sd51472};

  typedef enum logic [2:0] {
    REG_INNER_RADIUS = 3'd0,
    REG_PITCH_DIV0   = 3'd1,
    REG_ARC_DIV0     = 3'd2,
    REG_LAYERS_DIV0  = 3'd3,
    REG_PITCH_DIV1   = 3'd4,
    REG_ARC_DIV1     = 3'd5,
    REG_LAYERS_DIV1  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]         sec;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [19:0] z;
    logic [29:0]        r2;
    logic [14:0]        root;
    logic [29:0]        root_sq;
  } cord_t;

  typedef struct packed {
    logic [2:0]  sec;
    logic        dneg;
    logic [17:0] adelta;
    logic        below;
    logic        sel;
    logic [5:0]  k;
    logic [19:0] rmin;
  } ctl_t;

endpackage

FILE: rtl/core/polar_pad_plane_hit_locator.sv
// ----------------------------------------------------------------------------
// polar_pad_plane_hit_locator
// locates the pad of a hit on an octagonal plane: sector, signed row, layer
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_pos_x, in_pos_y
//  out     | output    | out_valid/out_stall | out_hit_valid, out_sector,
//          |           |                     | out_pad_row, out_pad_layer
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one hit per cycle while in_stall is low
// the pipeline runs through the 17 cordic cells and the 15 and 22 bit divider rows
// the whole row of cells advances together; it halts only while a result
// waits in the output register under out_stall
// synchronous reset clears valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module polar_pad_plane_hit_locator #(
  parameter int NUM_DIVISIONS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [14:0] in_pos_x,
  input  logic signed [14:0] in_pos_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit_valid,
  output logic [2:0]        out_sector,
  output logic signed [7:0] out_pad_row,
  output logic [6:0]        out_pad_layer,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [13:0]       cfg_data
);
  import pphl_pkg::*;
  `include "polar_pad_plane_hit_locator_assert.svh"

  logic        en;
  logic [13:0] r0_r;
  logic [11:0] p0_r, a0_r, p1_r, a1_r;
  logic [5:0]  l0_r, l1_r;
  logic [19:0] r1;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_r <= 14'd1600;
      p0_r <= 12'd192;
      a0_r <= 12'd48;
      l0_r <= 6'd16;
      p1_r <= 12'd192;
      a1_r <= 12'd48;
      l1_r <= 6'd26;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_INNER_RADIUS: r0_r <= cfg_data;
        REG_PITCH_DIV0:   p0_r <= cfg_data[11:0];
        REG_ARC_DIV0:     a0_r <= cfg_data[11:0];
        REG_LAYERS_DIV0:  l0_r <= cfg_data[5:0];
        REG_PITCH_DIV1:   p1_r <= cfg_data[11:0];
        REG_ARC_DIV1:     a1_r <= cfg_data[11:0];
        REG_LAYERS_DIV1:  l1_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign r1 = 20'(r0_r) + 20'(18'(l0_r) * 18'(p0_r));

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // front and cordic chain
  cord_t                   cord [CORDIC_STEPS+1];
  logic                    fv_r;
  logic [CORDIC_STEPS-1:0] cv_r;

  pphl_front u_front (
    .clk(clk), .en(en), .pos_x(in_pos_x), .pos_y(in_pos_y), .cord_o(cord[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pphl_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en), .cord_i(cord[i]), .cord_o(cord[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
      cv_r <= '0;
    end else if (en) begin
      fv_r <= in_valid;
      cv_r <= {cv_r[CORDIC_STEPS-2:0], fv_r};
    end
  end

  // angle offset, division pick, layer numerator
  cord_t              ce;
  logic signed [20:0] dl;
  logic               sel;
  ctl_t               st1_nxt, st1_r;
  logic [14:0]        lnum_nxt;
  logic               p1v_r;

  always_comb begin
    ce  = cord[CORDIC_STEPS];
    dl  = 21'(ce.z) - 21'(SECTOR_CENTRE[ce.sec]);
    if (dl > PI_Q16) dl = dl - TWO_PI_Q16;
    else if (dl <= -PI_Q16) dl = dl + TWO_PI_Q16;
    sel = (NUM_DIVISIONS >= 2) && (20'(ce.root) >= r1);
    st1_nxt        = '0;
    st1_nxt.sec    = ce.sec;
    st1_nxt.dneg   = dl > 0;
    st1_nxt.adelta = (dl < 0) ? 18'(-dl) : 18'(dl);
    st1_nxt.below  = ce.root < 15'(r0_r);
    st1_nxt.sel    = sel;
    if (sel) lnum_nxt = 15'(20'(ce.root) - r1);
    else if (!st1_nxt.below) lnum_nxt = ce.root - 15'(r0_r);
    else lnum_nxt = '0;
  end

  logic [LDIV_BITS-1:0] lnum [LDIV_BITS+1];
  logic [11:0]          lrem [LDIV_BITS+1];
  ctl_t                 lctl_r [LDIV_BITS];
  logic [LDIV_BITS-1:0] lv_r;
  logic [LDIV_BITS-1:0] lnum0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r   <= st1_nxt;
      lnum0_r <= lnum_nxt;
    end
  end
  assign lnum[0] = lnum0_r;
  assign lrem[0] = '0;

  for (genvar i = 0; i < LDIV_BITS; i++) begin : g_ldiv
    ctl_t lc;
    assign lc = (i == 0) ? st1_r : lctl_r[(i == 0) ? 0 : i-1];
    pphl_div_cell #(.NW(LDIV_BITS), .DW(12)) u_div (
      .clk(clk), .en(en), .divisor(lc.sel ? p1_r : p0_r),
      .num_i(lnum[i]), .rem_i(lrem[i]), .num_o(lnum[i+1]), .rem_o(lrem[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) lctl_r[i] <= lc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
      lv_r  <= '0;
    end else if (en) begin
      p1v_r <= cv_r[CORDIC_STEPS-1];
      lv_r  <= {lv_r[LDIV_BITS-2:0], p1v_r};
    end
  end

  // layer index and its inner radius
  ctl_t        lce, p2_nxt, p2_r;
  logic [5:0]  cnt;
  logic [19:0] base;
  logic [11:0] pit;
  logic        p2v_r;

  always_comb begin
    lce  = lctl_r[LDIV_BITS-1];
    cnt  = lce.sel ? l1_r : l0_r;
    base = lce.sel ? r1 : 20'(r0_r);
    pit  = lce.sel ? p1_r : p0_r;
    p2_nxt   = lce;
    p2_nxt.k = (lnum[LDIV_BITS] > 15'(cnt)) ? cnt : lnum[LDIV_BITS][5:0];
    p2_nxt.rmin = base + 20'(18'(p2_nxt.k) * 18'(pit));
  end

  // row and rows-per-half-layer numerators
  logic [37:0]          mprod;
  logic [50:0]          qprod;
  ctl_t                 p3_r;
  logic                 p3v_r;
  logic [RDIV_BITS-1:0] mnum [RDIV_BITS+1];
  logic [RDIV_BITS-1:0] qnum [RDIV_BITS+1];
  logic [11:0]          mrem [RDIV_BITS+1];
  logic [11:0]          qrem [RDIV_BITS+1];
  ctl_t                 rctl_r [RDIV_BITS];
  logic [RDIV_BITS-1:0] rv_r;
  logic [RDIV_BITS-1:0] mnum0_r, qnum0_r;

  always_comb begin
    mprod = 38'(p2_r.adelta) * 38'(p2_r.rmin);
    qprod = 51'(p2_r.rmin) * 51'(PI8_Q32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r    <= p2_nxt;
      p3_r    <= p2_r;
      mnum0_r <= mprod[37:16];
      qnum0_r <= RDIV_BITS'(qprod[50:32]);
    end
  end
  assign mnum[0] = mnum0_r;
  assign qnum[0] = qnum0_r;
  assign mrem[0] = '0;
  assign qrem[0] = '0;

  for (genvar i = 0; i < RDIV_BITS; i++) begin : g_rdiv
    ctl_t        rc;
    logic [11:0] arc;
    assign rc  = (i == 0) ? p3_r : rctl_r[(i == 0) ? 0 : i-1];
    assign arc = rc.sel ? a1_r : a0_r;
    pphl_div_cell #(.NW(RDIV_BITS), .DW(12)) u_mdiv (
      .clk(clk), .en(en), .divisor(arc),
      .num_i(mnum[i]), .rem_i(mrem[i]), .num_o(mnum[i+1]), .rem_o(mrem[i+1])
    );
    pphl_div_cell #(.NW(RDIV_BITS), .DW(12)) u_qdiv (
      .clk(clk), .en(en), .divisor(arc),
      .num_i(qnum[i]), .rem_i(qrem[i]), .num_o(qnum[i+1]), .rem_o(qrem[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) rctl_r[i] <= rc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2v_r <= 1'b0;
      p3v_r <= 1'b0;
      rv_r  <= '0;
    end else if (en) begin
      p2v_r <= lv_r[LDIV_BITS-1];
      p3v_r <= p2v_r;
      rv_r  <= {rv_r[RDIV_BITS-2:0], p3v_r};
    end
  end

  // final checks and output register
  ctl_t                 rce;
  logic [RDIV_BITS-1:0] mq, qq;
  logic [6:0]           first, total, layer;
  logic [11:0]          arc_e;
  logic [7:0]           mag;
  logic                 ok;
  logic                 out_valid_r, hit_r;
  logic [2:0]           sec_r;
  logic signed [7:0]    row_r;
  logic [6:0]           layer_r;

  always_comb begin
    rce   = rctl_r[RDIV_BITS-1];
    mq    = mnum[RDIV_BITS];
    qq    = qnum[RDIV_BITS];
    arc_e = rce.sel ? a1_r : a0_r;
    first = rce.sel ? 7'(l0_r) : 7'd0;
    total = 7'(l0_r) + ((NUM_DIVISIONS >= 2) ? 7'(l1_r) : 7'd0);
    layer = first + 7'(rce.k);
    mag   = 8'(mq) + 8'd1;
    ok    = !rce.below && (layer < total) && (arc_e != '0) &&
            (mq <= RDIV_BITS'(126)) && ((23'(mq) + 23'd2) <= 23'(qq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rv_r[RDIV_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r   <= ok;
      sec_r   <= rce.sec;
      row_r   <= !ok ? 8'sd0 : (rce.dneg ? -signed'(mag) : signed'(mag));
      layer_r <= ok ? layer : 7'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit_valid = hit_r;
  assign out_sector    = sec_r;
  assign out_pad_row   = row_r;
  assign out_pad_layer = layer_r;

  `PPHL_ASSERT_IMP(a_row_nonzero, out_valid && out_hit_valid, out_pad_row != 8'sd0)
  `PPHL_ASSERT_IMP(a_miss_zero, out_valid && !out_hit_valid, out_pad_row == 8'sd0 && out_pad_layer == 7'd0)
  `PPHL_ASSERT_NXT(a_drain, rv_r[RDIV_BITS-1] && en, out_valid)
  `PPHL_ASSERT_IMP(a_stall_link, in_stall, out_valid && out_stall)

endmodule

FILE: rtl/core/pphl_front.sv
// ----------------------------------------------------------------------------
// pphl_front
// sector test, squared radius and quadrant turn of the incoming hit
// ----------------------------------------------------------------------------
module pphl_front (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [14:0]    pos_x,
  input  logic signed [14:0]    pos_y,
  output pphl_pkg::cord_t       cord_o
);
  import pphl_pkg::*;

  logic signed [49:0] j, a1, a3;
  logic [2:0]         sec;
  logic signed [33:0] xs, ys;
  logic signed [29:0] xx, yy;
  cord_t              cord_nxt, cord_r;

  always_comb begin
    j  = 50'(pos_y) <<< 32;
    a1 = SLOPE1 * 50'(pos_x);
    a3 = SLOPE3 * 50'(pos_x);
    if (j > a3) begin
      if (j > a1) begin
        if (j > -a1) sec = (j > -a3) ? 3'd0 : 3'd1;
        else sec = 3'd2;
      end else begin
        sec = 3'd3;
      end
    end else if (j < a1) begin
      if (j < -a1) sec = (j < -a3) ? 3'd4 : 3'd5;
      else sec = 3'd6;
    end else begin
      sec = 3'd7;
    end
  end

  always_comb begin
    xs = 34'(pos_x) <<< 16;
    ys = 34'(pos_y) <<< 16;
    xx = 30'(pos_x) * 30'(pos_x);
    yy = 30'(pos_y) * 30'(pos_y);
    cord_nxt.sec     = sec;
    cord_nxt.r2      = 30'(xx) + 30'(yy);
    cord_nxt.root    = '0;
    cord_nxt.root_sq = '0;
    if (pos_x < 0) begin
      if (pos_y >= 0) begin
        cord_nxt.cx = ys;
        cord_nxt.cy = -xs;
        cord_nxt.z  = HALF_PI_Q16;
      end else begin
        cord_nxt.cx = -ys;
        cord_nxt.cy = xs;
        cord_nxt.z  = -HALF_PI_Q16;
      end
    end else begin
      cord_nxt.cx = xs;
      cord_nxt.cy = ys;
      cord_nxt.z  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) cord_r <= cord_nxt;
  end

  assign cord_o = cord_r;

endmodule

FILE: rtl/core/pphl_cordic_cell.sv
// ----------------------------------------------------------------------------
// pphl_cordic_cell
// one vectoring step of the angle and, in the first 15 steps, one bit of the radius square root
// ----------------------------------------------------------------------------
module pphl_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  pphl_pkg::cord_t cord_i,
  output pphl_pkg::cord_t cord_o
);
  import pphl_pkg::*;

  logic signed [33:0] dx, dy;
  logic signed [19:0] ang;
  cord_t              cord_nxt, cord_r;

  always_comb begin
    dx  = cord_i.cy >>> STEP;
    dy  = cord_i.cx >>> STEP;
    ang = signed'(20'(STEP_ANGLE[STEP]));
    cord_nxt = cord_i;
    if (cord_i.cy > 0) begin
      cord_nxt.cx = cord_i.cx + dx;
      cord_nxt.cy = cord_i.cy - dy;
      cord_nxt.z  = cord_i.z + ang;
    end else begin
      cord_nxt.cx = cord_i.cx - dx;
      cord_nxt.cy = cord_i.cy + dy;
      cord_nxt.z  = cord_i.z - ang;
    end
  end

  if (STEP < SQRT_BITS) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - STEP;
    logic [30:0] tsq;
    cord_t       cord_sq;
    always_comb begin
      tsq = 31'(cord_i.root_sq) + (31'(cord_i.root) << (B + 1)) + (31'(1) << (2 * B));
      cord_sq = cord_nxt;
      if (tsq <= 31'(cord_i.r2)) begin
        cord_sq.root    = cord_i.root | (15'(1) << B);
        cord_sq.root_sq = 30'(tsq);
      end
    end
    always_ff @(posedge clk) begin
      if (en) cord_r <= cord_sq;
    end
  end else begin : g_plain
    always_ff @(posedge clk) begin
      if (en) cord_r <= cord_nxt;
    end
  end

  assign cord_o = cord_r;

endmodule

FILE: rtl/core/pphl_div_cell.sv
// ----------------------------------------------------------------------------
// pphl_div_cell
// one restoring division step, quotient bits shift into the dividend word
// ----------------------------------------------------------------------------
module pphl_div_cell #(
  parameter int NW = 22,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] divisor,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o
);

  logic [DW:0]   t;
  logic          ge;
  logic [DW:0]   diff;
  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;

  always_comb begin
    t    = {rem_i, num_i[NW-1]};
    ge   = t >= {1'b0, divisor};
    diff = t - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {num_i[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : t[DW-1:0];
    end
  end

  assign num_o = num_r;
  assign rem_o = rem_r;

endmodule

FILE: verif/polar_pad_plane_hit_locator_test.sv
// ----------------------------------------------------------------------------
// polar_pad_plane_hit_locator_test
// self-checking bench: hit positions under random stalls and gaps across a
// range of register settings, each result checked against an in-bench
// pad locator model (sector test, layer search, cordic angle, row divide)
// ----------------------------------------------------------------------------
module polar_pad_plane_hit_locator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pphl_pkg::*;

  typedef struct packed {
    logic              hit_valid;
    logic [2:0]        sector;
    logic signed [7:0] pad_row;
    logic [6:0]        pad_layer;
  } pad_hit_t;

  localparam longint TAN1_Q32 = 64'sd1779033704;
  localparam longint TAN3_Q32 = 64'sd6074001000;
  localparam longint PI8_Q32L = 64'sd1686629713;
  localparam longint PI_Q16L = 64'sd205887;
  localparam longint TWO_PI_Q16L = 64'sd411775;
  localparam longint HALF_PI_Q16L = 64'sd102944;
  localparam int IDLE_LIMIT = 2000;
  localparam int DIVISIONS = 2;

  localparam longint ATAN_Q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1};
  localparam longint CENTRE_Q16 [8] = '{102944, 154416, 205887, -154416, -102944,
    -51472, 0, 51472};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [14:0] in_pos_x = '0;
  logic signed [14:0] in_pos_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit_valid;
  logic [2:0] out_sector;
  logic signed [7:0] out_pad_row;
  logic [6:0] out_pad_layer;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  longint plane_regs [7];
  pad_hit_t pad_hits_due [$];
  int mismatches = 0;
  int stray_results = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  polar_pad_plane_hit_locator #(.NUM_DIVISIONS(DIVISIONS)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pad_hit_t locate_pad(logic signed [14:0] px, logic signed [14:0] py);
    longint x, y, j, a1, a3, r2, r0, r1, base, pitch, arc, count, first, total;
    longint k, rmin, cx, cy, z, t, dx, dy, delta, adelta, nhalf, mag;
    bit ok;
    logic [2:0] sec;
    pad_hit_t res;
    x = longint'(px);
    y = longint'(py);
    j = y * 64'sd4294967296;
    a1 = TAN1_Q32 * x;
    a3 = TAN3_Q32 * x;
    if (j > a3) begin
      if (j > a1) sec = (j > -a1) ? ((j > -a3) ? 3'd0 : 3'd1) : 3'd2;
      else sec = 3'd3;
    end else if (j < a1) begin
      if (j < -a1) sec = (j < -a3) ? 3'd4 : 3'd5;
      else sec = 3'd6;
    end else begin
      sec = 3'd7;
    end
    r2 = x * x + y * y;
    r0 = plane_regs[REG_INNER_RADIUS];
    r1 = r0 + plane_regs[REG_LAYERS_DIV0] * plane_regs[REG_PITCH_DIV0];
    total = plane_regs[REG_LAYERS_DIV0] + ((DIVISIONS >= 2) ? plane_regs[REG_LAYERS_DIV1] : 0);
    if (DIVISIONS >= 2 && r2 >= r1 * r1) begin
      base = r1;
      pitch = plane_regs[REG_PITCH_DIV1];
      arc = plane_regs[REG_ARC_DIV1];
      count = plane_regs[REG_LAYERS_DIV1];
      first = plane_regs[REG_LAYERS_DIV0];
    end else begin
      base = r0;
      pitch = plane_regs[REG_PITCH_DIV0];
      arc = plane_regs[REG_ARC_DIV0];
      count = plane_regs[REG_LAYERS_DIV0];
      first = 0;
    end
    ok = (r2 >= r0 * r0);
    k = 0;
    while (k < count && (base + (k + 1) * pitch) * (base + (k + 1) * pitch) <= r2) k++;
    if (first + k >= total || arc == 0) ok = 1'b0;
    rmin = base + k * pitch;
    cx = x * 65536;
    cy = y * 65536;
    z = 0;
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; z = HALF_PI_Q16L;
      end else begin
        t = cx; cx = -cy; cy = t; z = -HALF_PI_Q16L;
      end
    end
    for (int i = 0; i < 17; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; z += ATAN_Q16[i];
      end else begin
        cx -= dx; cy += dy; z -= ATAN_Q16[i];
      end
    end
    delta = z - CENTRE_Q16[sec];
    if (delta > PI_Q16L) delta -= TWO_PI_Q16L;
    else if (delta <= -PI_Q16L) delta += TWO_PI_Q16L;
    adelta = (delta < 0) ? -delta : delta;
    res = '0;
    res.sector = sec;
    if (ok) begin
      nhalf = (rmin * PI8_Q32L) / (arc * 64'sd4294967296);
      mag = (adelta * rmin) / (arc * 65536) + 1;
      if (!(mag + 1 > nhalf || mag > 127)) begin
        res.hit_valid = 1'b1;
        res.pad_row = (delta > 0) ? -mag[7:0] : mag[7:0];
        res.pad_layer = 7'(first + k);
      end
    end
    return res;
  endfunction

  // stall bursts on the result side
  initial begin
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if (!quiet) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
      end
    end
  end

  // result check
  always @(posedge clk) begin
    pad_hit_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_hit_valid, out_sector, out_pad_row, out_pad_layer};
      if (pad_hits_due.size() == 0) begin
        stray_results++;
        $display("unexpected result: %p", got);
      end else begin
        want = pad_hits_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: valid %0d/%0d sector %0d/%0d row %0d/%0d layer %0d/%0d",
                     want.hit_valid, got.hit_valid, want.sector, got.sector,
                     want.pad_row, got.pad_row, want.pad_layer, got.pad_layer);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("polar_pad_plane_hit_locator_test failed");
      $finish;
    end
  end

  task automatic send_hit(logic signed [14:0] px, logic signed [14:0] py);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pad_hits_due.insert(pad_hits_due.size(), locate_pad(px, py));
  endtask

  task automatic drain_hits();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pad_hits_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 14'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INNER_RADIUS: plane_regs[idx] = val & 16'h3fff;
      REG_LAYERS_DIV0, REG_LAYERS_DIV1: plane_regs[idx] = val & 6'h3f;
      default: plane_regs[idx] = val & 12'hfff;
    endcase
  endtask

  task automatic set_plane(int unsigned r0, int unsigned p0, int unsigned a0, int unsigned l0,
                           int unsigned p1, int unsigned a1, int unsigned l1);
    drain_hits();
    write_reg(REG_INNER_RADIUS, r0);
    write_reg(REG_PITCH_DIV0, p0);
    write_reg(REG_ARC_DIV0, a0);
    write_reg(REG_LAYERS_DIV0, l0);
    write_reg(REG_PITCH_DIV1, p1);
    write_reg(REG_ARC_DIV1, a1);
    write_reg(REG_LAYERS_DIV1, l1);
  endtask

  task automatic send_random_hit();
    longint span;
    int m;
    span = plane_regs[REG_INNER_RADIUS]
         + plane_regs[REG_LAYERS_DIV0] * plane_regs[REG_PITCH_DIV0]
         + plane_regs[REG_LAYERS_DIV1] * plane_regs[REG_PITCH_DIV1] + 200;
    m = (span > 16383) ? 16383 : int'(span);
    if ($urandom_range(0, 3) != 0)
      send_hit(15'($urandom_range(0, 2 * m) - m), 15'($urandom_range(0, 2 * m) - m));
    else
      send_hit(15'($urandom), 15'($urandom));
  endtask

  task automatic test_directed();
    send_hit(0, 0);
    send_hit(0, 1600);
    send_hit(0, 1599);
    send_hit(0, -1600);
    send_hit(16383, 16383);
    send_hit(-16384, -16384);
    send_hit(-16384, 16383);
    send_hit(16383, -16384);
    send_hit(0, 16383);
    send_hit(-16384, 0);
    send_hit(1600, 0);
    send_hit(0, 1792);
    send_hit(0, 4671);
    send_hit(0, 4672);
    send_hit(0, 9663);
    send_hit(0, 9664);
    send_hit(1000, 2414);
    send_hit(3000, 4000);
    send_hit(-3000, 4000);
    send_hit(-5000, -1);
    send_hit(5000, -1);
    send_hit(2000, 2000);
    send_hit(-2000, -2000);
    send_hit(1, -1);
    send_hit(-1, 0);
  endtask

  task automatic test_register_extremes();
    set_plane(16383, 4095, 4095, 63, 4095, 4095, 63);
    repeat (30) send_random_hit();
    set_plane(0, 1, 1, 63, 1, 1, 63);
    repeat (30) send_random_hit();
    set_plane(1600, 192, 0, 16, 192, 0, 26);
    repeat (30) send_random_hit();
    set_plane(1600, 0, 48, 16, 0, 48, 26);
    repeat (30) send_random_hit();
    set_plane(1600, 192, 48, 0, 192, 48, 0);
    repeat (30) send_random_hit();
    set_plane(800, 100, 20, 0, 200, 30, 40);
    repeat (30) send_random_hit();
  endtask

  task automatic test_random_planes();
    for (int phase = 0; phase < 10; phase++) begin
      set_plane($urandom_range(0, 4000), $urandom_range(16, 600), $urandom_range(8, 400),
                $urandom_range(0, 40), $urandom_range(16, 600), $urandom_range(8, 400),
                $urandom_range(0, 40));
      if (phase == 9) quiet = 1'b1;
      for (int n = 0; n < 120; n++) begin
        if (phase == 4 && n == 60) drain_hits();
        send_random_hit();
      end
    end
  endtask

  initial begin
    plane_regs = '{1600, 192, 48, 16, 192, 48, 26};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_planes();
    drain_hits();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && stray_results == 0 && pad_hits_due.size() == 0)
      $display("polar_pad_plane_hit_locator_test passed");
    else
      $display("polar_pad_plane_hit_locator_test failed");
    $finish;
  end

endmodule
